### rtl/lph_pkg.sv
// Shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps

package lph_pkg;

	// Operation codes carried on the operation port
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	// Result codes carried on the status port
	typedef enum logic [1:0] {
		RES_INSERTED = 2'd0,
		RES_FULL     = 2'd1,
		RES_FOUND    = 2'd2,
		RES_MISSING  = 2'd3
	} result_t;

	// Home slot reduction: the key is padded to KEY_PAD_W bits and reduced
	// MOD_BITS bits a cycle, most significant first.
	localparam int KEY_W     = 31;
	localparam int KEY_PAD_W = 32;
	localparam int MOD_BITS  = 8;
	localparam int MOD_STEPS = KEY_PAD_W / MOD_BITS;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);
	localparam int SLOT_W    = 7;

	// One table slot as held in memory
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [7:0]       age;
		logic [63:0]      name_lo;
		logic [63:0]      name_mid;
		logic [31:0]      name_hi;
	} slot_entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_START,
		S_READ,
		S_CHECK
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    capture;
		logic    mod_step;
		logic    probe_start;
		logic    rd_en;
		logic    probe_adv;
		logic    write_ins;
		logic    clr_write;
		logic    out_load;
		result_t result;
		logic    hit;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic op_search;
		logic count_full;
		logic slot_valid;
		logic key_match;
		logic probes_done;
		logic last_slot;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/linear_probe_hash_table.sv
// Top level of the open-addressing hash table with linear probing.
// A request passes through home slot reduction, a set-up step, and then a read and a check
// of each probed slot; an insert into a full table is answered right after the reduction.
// A new request is taken only in the idle state, once the previous one has finished, and
// the probe loop stalls while the result register is still occupied.
// Reset: asynchronous; a clearing pass empties every slot, with no
// request accepted until it ends.
`timescale 1ns / 1ps

module linear_probe_hash_table #(
	parameter int TABLE_SIZE = 128
) (
	input  logic        clk,
	input  logic        arst_n,

	// Request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [30:0] record_key,
	input  logic [7:0]  record_age,
	input  logic [63:0] name_bytes_lo,
	input  logic [63:0] name_bytes_mid,
	input  logic [31:0] name_bytes_hi,

	// Result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [6:0]  slot_index,
	output logic [7:0]  found_age,
	output logic [63:0] found_name_lo,
	output logic [63:0] found_name_mid,
	output logic [31:0] found_name_hi
);

	// The controller decides what happens each cycle; the datapath holds the
	// request, the home slot remainder, the probe pointer, the record count,
	// the slot memory and the result register. They talk only through these.
	lph_pkg::ctrl_cmd_t  cmd;
	lph_pkg::dp_status_t sts;

	lph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The result register decouples the two channels: a new request can be
	// taken while the previous result still waits to be collected, and the
	// probe loop only stalls when it has a fresh result and the register is
	// still occupied.
	lph_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.operation      (operation),
		.record_key     (record_key),
		.record_age     (record_age),
		.name_bytes_lo  (name_bytes_lo),
		.name_bytes_mid (name_bytes_mid),
		.name_bytes_hi  (name_bytes_hi),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot_index     (slot_index),
		.found_age      (found_age),
		.found_name_lo  (found_name_lo),
		.found_name_mid (found_name_mid),
		.found_name_hi  (found_name_hi)
	);

endmodule

### rtl/lph_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module lph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/lph_ctrl.sv
// Controller state machine sequencing clear, hashing and probing.
`timescale 1ns / 1ps

module lph_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lph_pkg::dp_status_t    sts,
	output lph_pkg::ctrl_cmd_t     cmd
);

	lph_pkg::ctrl_state_t state_q, state_d;
	logic [lph_pkg::MOD_CNT_W-1:0] mod_cnt_q, mod_cnt_d;

	localparam logic [lph_pkg::MOD_CNT_W-1:0] MOD_LAST =
		lph_pkg::MOD_CNT_W'(lph_pkg::MOD_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lph_pkg::S_CLEAR;
			mod_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			mod_cnt_q <= mod_cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mod_cnt_d  = mod_cnt_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.result = lph_pkg::RES_INSERTED;
		case (state_q)
			lph_pkg::S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (sts.last_slot) begin
					state_d = lph_pkg::S_IDLE;
				end
			end
			lph_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					mod_cnt_d   = '0;
					state_d     = lph_pkg::S_MOD;
				end
			end
			lph_pkg::S_MOD: begin
				cmd.mod_step = 1'b1;
				mod_cnt_d    = mod_cnt_q + 1'b1;
				if (mod_cnt_q == MOD_LAST) begin
					state_d = lph_pkg::S_START;
				end
			end
			lph_pkg::S_START: begin
				if (!sts.op_search && sts.count_full) begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.result   = lph_pkg::RES_FULL;
						state_d      = lph_pkg::S_IDLE;
					end
				end else begin
					cmd.probe_start = 1'b1;
					state_d         = lph_pkg::S_READ;
				end
			end
			lph_pkg::S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = lph_pkg::S_CHECK;
			end
			lph_pkg::S_CHECK: begin
				if (!sts.op_search) begin
					if (!sts.slot_valid) begin
						if (sts.out_free) begin
							cmd.write_ins = 1'b1;
							cmd.out_load  = 1'b1;
							cmd.result    = lph_pkg::RES_INSERTED;
							state_d       = lph_pkg::S_IDLE;
						end
					end else if (sts.probes_done) begin
						if (sts.out_free) begin
							cmd.out_load = 1'b1;
							cmd.result   = lph_pkg::RES_FULL;
							state_d      = lph_pkg::S_IDLE;
						end
					end else begin
						cmd.probe_adv = 1'b1;
						state_d       = lph_pkg::S_READ;
					end
				end else begin
					if (sts.slot_valid && sts.key_match) begin
						if (sts.out_free) begin
							cmd.out_load = 1'b1;
							cmd.result   = lph_pkg::RES_FOUND;
							cmd.hit      = 1'b1;
							state_d      = lph_pkg::S_IDLE;
						end
					end else if (!sts.slot_valid || sts.probes_done) begin
						if (sts.out_free) begin
							cmd.out_load = 1'b1;
							cmd.result   = lph_pkg::RES_MISSING;
							state_d      = lph_pkg::S_IDLE;
						end
					end else begin
						cmd.probe_adv = 1'b1;
						state_d       = lph_pkg::S_READ;
					end
				end
			end
			default: begin
				state_d = lph_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### rtl/lph_dp.sv
// Datapath: request capture, home slot reduction, probe pointer, slot memory, result register.
`timescale 1ns / 1ps

module lph_dp #(
	parameter int TABLE_SIZE = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       operation,
	input  logic [lph_pkg::KEY_W-1:0]  record_key,
	input  logic [7:0]                 record_age,
	input  logic [63:0]                name_bytes_lo,
	input  logic [63:0]                name_bytes_mid,
	input  logic [31:0]                name_bytes_hi,
	input  lph_pkg::ctrl_cmd_t         cmd,
	output lph_pkg::dp_status_t        sts,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [lph_pkg::SLOT_W-1:0] slot_index,
	output logic [7:0]                 found_age,
	output logic [63:0]                found_name_lo,
	output logic [63:0]                found_name_mid,
	output logic [31:0]                found_name_hi
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam int ENT_W = $bits(lph_pkg::slot_entry_t);
	localparam logic [IDX_W:0]   MODULUS   = (IDX_W + 1)'(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_SIZE);

	// Captured request
	logic                          op_q;
	logic [lph_pkg::KEY_W-1:0]     key_q;
	logic [7:0]                    age_q;
	logic [63:0]                   name_lo_q;
	logic [63:0]                   name_mid_q;
	logic [31:0]                   name_hi_q;
	logic [lph_pkg::KEY_PAD_W-1:0] keysh_q;

	// Hashing and probing
	logic [IDX_W-1:0] rem_q, rem_next;
	logic [IDX_W:0]   rem_wide;
	logic [IDX_W-1:0] probe_q, probe_next;
	logic [IDX_W-1:0] probes_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      probe_wide;

	lph_pkg::slot_entry_t wr_entry, rd_entry;
	logic [ENT_W-1:0]     rd_bits;
	logic                 out_valid_q;

	// Restoring remainder, MOD_BITS key bits per cycle
	always_comb begin
		rem_next = rem_q;
		rem_wide = '0;
		for (int b = 0; b < lph_pkg::MOD_BITS; b++) begin
			rem_wide = {rem_next, keysh_q[lph_pkg::KEY_PAD_W-1-b]};
			if (rem_wide >= MODULUS) begin
				rem_wide = rem_wide - MODULUS;
			end
			rem_next = rem_wide[IDX_W-1:0];
		end
	end

	assign probe_next = (probe_q == LAST_SLOT) ? '0 : probe_q + IDX_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= operation;
			key_q      <= record_key;
			age_q      <= record_age;
			name_lo_q  <= name_bytes_lo;
			name_mid_q <= name_bytes_mid;
			name_hi_q  <= name_bytes_hi;
			keysh_q    <= {1'b0, record_key};
			rem_q      <= '0;
		end else if (cmd.mod_step) begin
			rem_q   <= rem_next;
			keysh_q <= keysh_q << lph_pkg::MOD_BITS;
		end
		if (cmd.probe_start) begin
			probes_q <= '0;
		end else if (cmd.probe_adv) begin
			probes_q <= probes_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.probe_start) begin
				probe_q <= rem_q;
			end else if (cmd.probe_adv || cmd.clr_write) begin
				probe_q <= probe_next;
			end
			if (cmd.write_ins) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		wr_entry = '0;
		if (!cmd.clr_write) begin
			wr_entry.valid    = 1'b1;
			wr_entry.key      = key_q;
			wr_entry.age      = age_q;
			wr_entry.name_lo  = name_lo_q;
			wr_entry.name_mid = name_mid_q;
			wr_entry.name_hi  = name_hi_q;
		end
	end

	lph_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_SIZE)
	) u_slots (
		.clk   (clk),
		.we    (cmd.write_ins | cmd.clr_write),
		.waddr (probe_q),
		.wdata (wr_entry),
		.re    (cmd.rd_en),
		.raddr (probe_q),
		.rdata (rd_bits)
	);

	assign rd_entry = lph_pkg::slot_entry_t'(rd_bits);

	assign sts.op_search   = (op_q == lph_pkg::OP_SEARCH);
	assign sts.count_full  = (count_q == FULL_CNT);
	assign sts.slot_valid  = rd_entry.valid;
	assign sts.key_match   = (rd_entry.key == key_q);
	assign sts.probes_done = (probes_q == LAST_SLOT);
	assign sts.last_slot   = (probe_q == LAST_SLOT);
	assign sts.out_free    = !out_valid_q || out_ready;

	assign probe_wide = 32'(probe_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status <= cmd.result;
			if (cmd.hit || cmd.result == lph_pkg::RES_INSERTED) begin
				slot_index <= probe_wide[lph_pkg::SLOT_W-1:0];
			end else begin
				slot_index <= '0;
			end
			if (cmd.hit) begin
				found_age      <= rd_entry.age;
				found_name_lo  <= rd_entry.name_lo;
				found_name_mid <= rd_entry.name_mid;
				found_name_hi  <= rd_entry.name_hi;
			end else begin
				found_age      <= '0;
				found_name_lo  <= '0;
				found_name_mid <= '0;
				found_name_hi  <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/lph_checker.sv
// Port-level checker for the hash table, bound to the top level.
`timescale 1ns / 1ps

module lph_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [6:0]  slot_index,
	input logic [7:0]  found_age,
	input logic [63:0] found_name_lo,
	input logic [63:0] found_name_mid,
	input logic [31:0] found_name_hi
);

	// One request at a time: the request port closes right after an acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request port still open after acceptance");

	// A stalled result holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index))
		else $error("stalled result changed");

	// Only a hit carries record data.
	a_no_data_without_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != lph_pkg::RES_FOUND |-> found_age == 8'd0
			&& found_name_lo == 64'd0 && found_name_mid == 64'd0
			&& found_name_hi == 32'd0)
		else $error("record data on a result that is not a hit");

	// Full and missing results carry no slot.
	a_no_slot_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == lph_pkg::RES_FULL || status == lph_pkg::RES_MISSING)
			|-> slot_index == 7'd0)
		else $error("slot index on a full or missing result");

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (.*);
